>>> hw/rtl/wbt_pkg.sv
// Package for the work/break cycle timer: request, response, config and state
// types, command and phase codes, and the constant divide by the ms-per-second rate.
// No dependencies.
`timescale 1ns / 1ps

package wbt_pkg;

  // Timestamp rate
  localparam int unsigned MS_PER_SECOND = 1000;

  // The divide is only needed while the elapsed time still fits a 16-bit second count
  localparam int unsigned DIV_W       = $clog2(64'(65536) * 64'(MS_PER_SECOND));
  localparam int unsigned MS_LOG      = $clog2(MS_PER_SECOND);
  localparam int unsigned RECIP_SHIFT = DIV_W + MS_LOG;
  localparam int unsigned RECIP_W     = DIV_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'(1) << RECIP_SHIFT) + 64'(MS_PER_SECOND) - 64'(1)) / 64'(MS_PER_SECOND));

  // Command codes
  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_START  = 3'd1;
  localparam logic [2:0] FUNC_PAUSE  = 3'd2;
  localparam logic [2:0] FUNC_TOGGLE = 3'd3;
  localparam logic [2:0] FUNC_RESET  = 3'd4;

  // Reported phase codes
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_WORK   = 3'd1;
  localparam logic [2:0] PH_BREAK  = 3'd2;
  localparam logic [2:0] PH_LONG   = 3'd3;
  localparam logic [2:0] PH_PAUSED = 3'd4;

  // Config register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WORK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BREAK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROUNDS = 2'd3;

  localparam logic [15:0] WORK_RESET   = 16'd1500;
  localparam logic [15:0] BREAK_RESET  = 16'd300;
  localparam logic [15:0] LONG_RESET   = 16'd900;
  localparam logic [3:0]  ROUNDS_RESET = 4'd4;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_WORK   = 5'b00010,
    ST_BREAK  = 5'b00100,
    ST_LONG   = 5'b01000,
    ST_PAUSED = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] now_ms;
  } wbt_req_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [3:0]  round_number;
    logic [15:0] remaining_seconds;
    logic [15:0] total_seconds;
    logic        phase_changed;
  } wbt_rsp_t;

  typedef struct packed {
    logic [15:0] work_secs;
    logic [15:0] break_secs;
    logic [15:0] long_secs;
    logic [3:0]  rounds;
  } wbt_cfg_t;

  typedef struct packed {
    phase_e      phase;
    phase_e      resume;
    logic [3:0]  round_cnt;
    logic [15:0] secs_left;
    logic [15:0] phase_len;
    logic [31:0] last_ms;
  } wbt_state_t;

  // Floor of n / MS_PER_SECOND by reciprocal multiply; exact for all n below 2^DIV_W,
  // whose quotient needs 17 bits
  function automatic logic [16:0] div_ms(input logic [DIV_W-1:0] n);
    logic [DIV_W+RECIP_W-1:0] prod;
    prod = (DIV_W+RECIP_W)'(n) * (DIV_W+RECIP_W)'(RECIP);
    return prod[RECIP_SHIFT +: 17];
  endfunction

endpackage

>>> hw/rtl/wbt_step.sv
// Next-state and status logic of the work/break cycle timer for one request.
// Depends on wbt_pkg.
`timescale 1ns / 1ps

module wbt_step (
  input  wbt_pkg::wbt_state_t st_i,
  input  wbt_pkg::wbt_cfg_t   cfg_i,
  input  wbt_pkg::wbt_req_t   req_i,
  output wbt_pkg::wbt_state_t st_o,
  output wbt_pkg::wbt_rsp_t   rsp_o
);

  logic                      running;
  logic                      can_start;
  logic [31:0]               delta;
  logic                      under_sec;
  logic                      fits;
  logic [16:0]               elapsed;
  logic                      expire;
  logic                      changed;
  wbt_pkg::wbt_state_t       nx;

  assign running   = (st_i.phase == wbt_pkg::ST_WORK) || (st_i.phase == wbt_pkg::ST_BREAK) ||
                     (st_i.phase == wbt_pkg::ST_LONG);
  assign can_start = (st_i.phase == wbt_pkg::ST_IDLE) || (st_i.phase == wbt_pkg::ST_PAUSED);

  // Elapsed whole seconds; beyond 2^DIV_W ms it surely exceeds any count
  assign delta     = req_i.now_ms - st_i.last_ms;
  assign under_sec = delta < 32'(wbt_pkg::MS_PER_SECOND);
  assign fits      = (delta >> wbt_pkg::DIV_W) == 32'd0;
  assign elapsed   = wbt_pkg::div_ms(delta[wbt_pkg::DIV_W-1:0]);
  assign expire    = !fits || (elapsed >= {1'b0, st_i.secs_left});

  always_comb begin
    nx      = st_i;
    changed = 1'b0;
    case (req_i.func)
      wbt_pkg::FUNC_TICK: begin
        if (!running) begin
          nx.last_ms = req_i.now_ms;
        end else if (!under_sec) begin
          nx.last_ms = req_i.now_ms;
          if (!expire) begin
            nx.secs_left = st_i.secs_left - elapsed[15:0];
          end else begin
            changed = 1'b1;
            if (st_i.phase == wbt_pkg::ST_WORK) begin
              if (st_i.round_cnt >= cfg_i.rounds) begin
                nx.phase     = wbt_pkg::ST_LONG;
                nx.phase_len = cfg_i.long_secs;
                nx.round_cnt = 4'd1;
              end else begin
                nx.phase     = wbt_pkg::ST_BREAK;
                nx.phase_len = cfg_i.break_secs;
                nx.round_cnt = st_i.round_cnt + 4'd1;
              end
            end else begin
              nx.phase     = wbt_pkg::ST_WORK;
              nx.phase_len = cfg_i.work_secs;
            end
            nx.secs_left = nx.phase_len;
          end
        end
      end
      wbt_pkg::FUNC_START, wbt_pkg::FUNC_PAUSE, wbt_pkg::FUNC_TOGGLE: begin
        // Toggle pauses a running phase and starts otherwise
        if (running && (req_i.func != wbt_pkg::FUNC_START)) begin
          nx.resume = st_i.phase;
          nx.phase  = wbt_pkg::ST_PAUSED;
        end else if (can_start && (req_i.func != wbt_pkg::FUNC_PAUSE)) begin
          changed    = 1'b1;
          nx.last_ms = req_i.now_ms;
          if (st_i.phase == wbt_pkg::ST_IDLE) begin
            nx.phase     = wbt_pkg::ST_WORK;
            nx.phase_len = cfg_i.work_secs;
            nx.secs_left = cfg_i.work_secs;
          end else if ((st_i.resume == wbt_pkg::ST_BREAK) ||
                       (st_i.resume == wbt_pkg::ST_LONG)) begin
            nx.phase = st_i.resume;
          end else begin
            nx.phase = wbt_pkg::ST_WORK;
          end
        end
      end
      wbt_pkg::FUNC_RESET: begin
        nx.phase     = wbt_pkg::ST_IDLE;
        nx.round_cnt = 4'd1;
        nx.phase_len = cfg_i.work_secs;
        nx.secs_left = cfg_i.work_secs;
        nx.last_ms   = req_i.now_ms;
      end
      default: begin
        nx = st_i;
      end
    endcase
  end

  always_comb begin
    case (nx.phase)
      wbt_pkg::ST_WORK:   rsp_o.phase = wbt_pkg::PH_WORK;
      wbt_pkg::ST_BREAK:  rsp_o.phase = wbt_pkg::PH_BREAK;
      wbt_pkg::ST_LONG:   rsp_o.phase = wbt_pkg::PH_LONG;
      wbt_pkg::ST_PAUSED: rsp_o.phase = wbt_pkg::PH_PAUSED;
      default:            rsp_o.phase = wbt_pkg::PH_IDLE;
    endcase
  end

  assign rsp_o.round_number      = nx.round_cnt;
  assign rsp_o.remaining_seconds = nx.secs_left;
  assign rsp_o.total_seconds     = nx.phase_len;
  assign rsp_o.phase_changed     = changed;
  assign st_o                    = nx;

endmodule

>>> hw/rtl/work_break_cycle_timer_core.sv
// Top level of the work/break cycle timer: handshake, config registers, timer state.
// Depends on wbt_pkg and wbt_step.
`timescale 1ns / 1ps

// Work/break cycle timer. Each request carries a command (tick, start, pause,
// toggle, reset) and a free-running millisecond timestamp; each request returns
// exactly one status response with phase, round, seconds left, phase length and
// a phase-changed flag. Throughput is one request per clock while the output
// is not stalled: the request lands in an input register, and once the
// response register is free or draining, the state update (32-bit timestamp
// subtract, constant reciprocal multiply for the divide by 1000, compare and
// subtract against the seconds left) writes both the timer state and the
// response register. A stalled output only holds the input side once both
// registers are full. Config registers take effect when a phase length is next
// loaded; write them only while no request is in flight.

module work_break_cycle_timer_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  wbt_pkg::wbt_req_t                  in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output wbt_pkg::wbt_rsp_t                  out_rsp_o,
  input  logic                               cfg_we_i,
  input  logic [wbt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [15:0]                        cfg_data_i
);

  wbt_pkg::wbt_cfg_t   cfg_q;
  wbt_pkg::wbt_state_t st_q, st_d;
  wbt_pkg::wbt_req_t   req_q;
  wbt_pkg::wbt_rsp_t   rsp_q, rsp_d;
  logic                req_valid_q;
  logic                rsp_valid_q;
  logic                out_free;
  logic                step_fire;

  // Advance a held request whenever the response register is free or draining
  assign out_free   = !rsp_valid_q || out_ready_i;
  assign step_fire  = req_valid_q && out_free;
  assign in_ready_o = !req_valid_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{work_secs:  wbt_pkg::WORK_RESET,
                 break_secs: wbt_pkg::BREAK_RESET,
                 long_secs:  wbt_pkg::LONG_RESET,
                 rounds:     wbt_pkg::ROUNDS_RESET};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wbt_pkg::REG_WORK:   cfg_q.work_secs  <= cfg_data_i;
        wbt_pkg::REG_BREAK:  cfg_q.break_secs <= cfg_data_i;
        wbt_pkg::REG_LONG:   cfg_q.long_secs  <= cfg_data_i;
        wbt_pkg::REG_ROUNDS: cfg_q.rounds     <= cfg_data_i[3:0];
        default:             cfg_q            <= cfg_q;
      endcase
    end
  end

  // Input register: load on accept, drop once stepped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
  end

  wbt_step u_step (
    .st_i  (st_q),
    .cfg_i (cfg_q),
    .req_i (req_q),
    .st_o  (st_d),
    .rsp_o (rsp_d)
  );

  // Timer state: commit only when a request is stepped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase:     wbt_pkg::ST_IDLE,
                resume:    wbt_pkg::ST_WORK,
                round_cnt: 4'd1,
                secs_left: wbt_pkg::WORK_RESET,
                phase_len: wbt_pkg::WORK_RESET,
                last_ms:   32'd0};
    end else if (step_fire) begin
      st_q <= st_d;
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (out_free) begin
      rsp_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_valid_q;
  assign out_rsp_o   = rsp_q;

  // A stepped request always shows up as a response next cycle
  a_step_to_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |=> rsp_valid_q)
    else $error("stepped request did not produce a response");

  // Seconds left never exceed the phase length
  a_left_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.secs_left <= st_q.phase_len)
    else $error("seconds left above phase length");

  // A phase change always lands in a running phase
  a_changed_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_q.phase_changed) |->
      (rsp_q.phase == wbt_pkg::PH_WORK || rsp_q.phase == wbt_pkg::PH_BREAK ||
       rsp_q.phase == wbt_pkg::PH_LONG))
    else $error("phase change reported outside a running phase");

  // Round count never wraps to zero
  a_round_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.round_cnt != 4'd0)
    else $error("round count reached zero");

  // Timer state only moves when a request is stepped
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_fire |=> $stable(st_q))
    else $error("timer state changed without a request");

endmodule
